[rtl/core/cbor_head_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// cbor_head_decoder_core_macros
// Assertion helpers for the CBOR head decoder.
// ----------------------------------------------------------------------------
`ifndef CBOR_HEAD_DECODER_CORE_MACROS_SVH
`define CBOR_HEAD_DECODER_CORE_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define CBOR_HD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define CBOR_HD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   `CBOR_HD_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

`endif

[rtl/core/cbor_hd_pkg.sv]
// ----------------------------------------------------------------------------
// cbor_hd_pkg
// Shared types and constants of the CBOR head decoder.
// ----------------------------------------------------------------------------
package cbor_hd_pkg;

   localparam logic [4:0] AI_DIRECT_MAX  = 5'd23;
   localparam logic [4:0] AI_ONE_BYTE    = 5'h18;
   localparam logic [4:0] AI_TWO_BYTES   = 5'h19;
   localparam logic [4:0] AI_FOUR_BYTES  = 5'h1a;
   localparam logic [4:0] AI_EIGHT_BYTES = 5'h1b;
   localparam logic [4:0] AI_INDEFINITE  = 5'h1f;
   localparam logic [2:0] MAJOR_NEGATIVE = 3'd1;
   localparam logic [2:0] MAJOR_SIMPLE   = 3'd7;

   localparam int FifoDepth = 4;
   localparam int FifoAw    = $clog2(FifoDepth);

   typedef logic [7:0]  byte_type;
   typedef logic [2:0]  major_type;
   typedef logic [3:0]  len_type;
   typedef logic [63:0] value_type;

   // What the back end does with one byte.
   typedef enum logic [1:0] {
      TOK_HEAD  = 2'd0,  // head complete in its initial byte
      TOK_START = 2'd1,  // initial byte, argument bytes follow
      TOK_ARG   = 2'd2,  // argument byte, more follow
      TOK_LAST  = 2'd3   // final argument byte
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      major_type    major;
      byte_type     data;
      len_type      length;
      logic         indef;
      logic         brk;
      logic         rsv;
   } token_type;

   function automatic value_type finish_value(input major_type major, input value_type arg);
      return (major == MAJOR_NEGATIVE) ? ~arg : arg;
   endfunction

endpackage

[rtl/core/cbor_hd_front.sv]
// ----------------------------------------------------------------------------
// cbor_hd_front
// Tracks head framing and tags each stream byte with its role.
// ----------------------------------------------------------------------------
module cbor_hd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  cbor_hd_pkg::byte_type   data_byte,
   output cbor_hd_pkg::token_type  token
);
   import cbor_hd_pkg::*;

   logic [3:0] bytes_left_ff, bytes_left_in;
   major_type  major_ff, major_in;
   len_type    total_ff, total_in;

   logic [4:0] ai;
   major_type  mj;

   assign ai = data_byte[4:0];
   assign mj = data_byte[7:5];

   always_comb begin
      token          = '0;
      token.data     = data_byte;
      token.major    = mj;
      token.length   = 4'd1;
      bytes_left_in  = bytes_left_ff;
      major_in       = major_ff;
      total_in       = total_ff;
      if (bytes_left_ff != 4'd0) begin
         token.kind    = (bytes_left_ff == 4'd1) ? TOK_LAST : TOK_ARG;
         token.major   = major_ff;
         token.length  = total_ff + 4'd1;
         bytes_left_in = bytes_left_ff - 4'd1;
         total_in      = total_ff + 4'd1;
      end else begin
         token.kind = TOK_HEAD;
         case (ai) inside
            [5'd0:AI_DIRECT_MAX]: begin
               token.kind = TOK_HEAD;
            end
            AI_INDEFINITE: begin
               token.indef = 1'b1;
               token.brk   = (mj == MAJOR_SIMPLE);
            end
            AI_ONE_BYTE, AI_TWO_BYTES, AI_FOUR_BYTES, AI_EIGHT_BYTES: begin
               token.kind = TOK_START;
               major_in   = mj;
               total_in   = 4'd1;
               case (ai)
                  AI_ONE_BYTE:   bytes_left_in = 4'd1;
                  AI_TWO_BYTES:  bytes_left_in = 4'd2;
                  AI_FOUR_BYTES: bytes_left_in = 4'd4;
                  default:       bytes_left_in = 4'd8;
               endcase
            end
            default: begin
               token.rsv = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         major_ff      <= '0;
         total_ff      <= '0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
         major_ff      <= major_in;
         total_ff      <= total_in;
      end
   end

endmodule

[rtl/core/cbor_hd_fifo.sv]
// ----------------------------------------------------------------------------
// cbor_hd_fifo
// Short token queue between front and back end.
// ----------------------------------------------------------------------------
module cbor_hd_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cbor_hd_pkg::token_type push_data,
   output logic                  full,
   input  logic                  pop,
   output cbor_hd_pkg::token_type pop_data,
   output logic                  empty
);
   import cbor_hd_pkg::*;

   token_type          mem_ff [FifoDepth];
   logic [FifoAw-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FifoAw-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FifoAw:0]    count_ff, count_in;

   assign full     = (count_ff == (FifoAw+1)'(FifoDepth));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FifoAw'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FifoAw'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + (FifoAw+1)'(1);
      else if (pop && !push)
         count_in = count_ff - (FifoAw+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/cbor_hd_back.sv]
// ----------------------------------------------------------------------------
// cbor_hd_back
// Gathers argument bytes, forms the head value and holds the result item.
// ----------------------------------------------------------------------------
module cbor_hd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tok_valid,
   input  cbor_hd_pkg::token_type tok,
   output logic                   tok_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_major_type,
   output logic signed [63:0]     rsp_head_value,
   output logic                   rsp_is_indefinite,
   output logic                   rsp_is_break,
   output logic                   rsp_reserved_info,
   output logic [3:0]             rsp_head_length
);
   import cbor_hd_pkg::*;

   value_type acc_ff, acc_in;
   logic      valid_ff, valid_in;
   token_type out_ff, out_in;
   value_type value_ff, value_in;
   logic      out_ready, done;
   value_type shifted;

   assign out_ready = !valid_ff || !rsp_stall;
   assign done      = (tok.kind == TOK_HEAD) || (tok.kind == TOK_LAST);
   // tokens that emit nothing never wait on the output
   assign tok_pop   = tok_valid && (!done || out_ready);
   assign shifted   = {acc_ff[55:0], tok.data};

   always_comb begin
      acc_in   = acc_ff;
      out_in   = out_ff;
      value_in = value_ff;
      valid_in = valid_ff && rsp_stall;
      if (tok_pop) begin
         case (tok.kind)
            TOK_START: acc_in = '0;
            TOK_ARG:   acc_in = shifted;
            TOK_LAST: begin
               acc_in   = '0;
               valid_in = 1'b1;
               out_in   = tok;
               value_in = finish_value(tok.major, shifted);
            end
            default: begin
               valid_in = 1'b1;
               out_in   = tok;
               if (tok.indef)
                  value_in = '1;
               else if (tok.rsv)
                  value_in = '0;
               else
                  value_in = finish_value(tok.major, {59'd0, tok.data[4:0]});
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      out_ff   <= out_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_major_type    = out_ff.major;
   assign rsp_head_value    = value_ff;
   assign rsp_is_indefinite = out_ff.indef;
   assign rsp_is_break      = out_ff.brk;
   assign rsp_reserved_info = out_ff.rsv;
   assign rsp_head_length   = out_ff.length;

endmodule

[rtl/core/cbor_head_decoder_core.sv]
// ----------------------------------------------------------------------------
// cbor_head_decoder_core
// CBOR data item head decoder, one result item per head.
// ----------------------------------------------------------------------------
// Takes one CBOR stream byte per cycle while req_stall is low and gives one
// result item for every completed head (1 to 9 bytes). A front end tags each
// byte with its role, a four-entry token queue decouples it from the back end,
// which shifts argument bytes into a 64-bit accumulator and loads the output
// register. Sustained rate is one byte per cycle while req_stall is low, set
// by the single shift step of the accumulator; the last byte of a head passes
// the token queue and then the output register before rsp_valid rises. While
// rsp_stall is held, argument bytes that complete no head keep draining; the
// queue then fills with up to four more bytes before req_stall rises.
module cbor_head_decoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_major_type,
   output logic signed [63:0] rsp_head_value,
   output logic               rsp_is_indefinite,
   output logic               rsp_is_break,
   output logic               rsp_reserved_info,
   output logic [3:0]         rsp_head_length
);
   import cbor_hd_pkg::*;

   token_type front_tok, back_tok;
   logic      accept, full, empty, pop;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   cbor_hd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .token     (front_tok)
   );

   cbor_hd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_tok),
      .full      (full),
      .pop       (pop),
      .pop_data  (back_tok),
      .empty     (empty)
   );

   cbor_hd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .tok_valid         (!empty),
      .tok               (back_tok),
      .tok_pop           (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_major_type    (rsp_major_type),
      .rsp_head_value    (rsp_head_value),
      .rsp_is_indefinite (rsp_is_indefinite),
      .rsp_is_break      (rsp_is_break),
      .rsp_reserved_info (rsp_reserved_info),
      .rsp_head_length   (rsp_head_length)
   );

endmodule

[rtl/core/cbor_hd_checker.sv]
// ----------------------------------------------------------------------------
// cbor_hd_checker
// Port-level checks of the CBOR head decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "cbor_head_decoder_core_macros.svh"

module cbor_hd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_data_byte,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_major_type,
   input logic signed [63:0] rsp_head_value,
   input logic               rsp_is_indefinite,
   input logic               rsp_is_break,
   input logic               rsp_reserved_info,
   input logic [3:0]         rsp_head_length
);

   `CBOR_HD_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, ##1 (rsp_valid && $stable(rsp_head_value) && $stable(rsp_head_length)), "result item changed while stalled")
   `CBOR_HD_ASSERT_IMPL(a_len_range, clock, reset, rsp_valid, (rsp_head_length >= 4'd1) && (rsp_head_length <= 4'd9), "head length out of range")
   `CBOR_HD_ASSERT_IMPL(a_break, clock, reset, rsp_valid && rsp_is_break, (rsp_major_type == 3'd7) && rsp_is_indefinite && (rsp_head_value == -64'sd1) && (rsp_head_length == 4'd1), "bad break item")
   `CBOR_HD_ASSERT_IMPL(a_reserved, clock, reset, rsp_valid && rsp_reserved_info, (rsp_head_value == 64'sd0) && (rsp_head_length == 4'd1) && !rsp_is_indefinite, "bad reserved item")
   `CBOR_HD_ASSERT_IMPL(a_long_head, clock, reset, rsp_valid && (rsp_head_length != 4'd1), !rsp_is_indefinite && !rsp_reserved_info && !rsp_is_break, "multi-byte head carries flags")

endmodule

bind cbor_head_decoder_core cbor_hd_checker u_cbor_hd_checker (.*);

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for cbor_head_decoder_core.
// ----------------------------------------------------------------------------
// Feeds a CBOR byte stream: a short directed list of heads, then random
// heads of every length and kind mixed with noise bytes. A local decoder
// predicts each completed head as its bytes are accepted. Each result item
// is checked field by field in order against those predictions. Both sides
// idle at random. The receiver also holds off for long stretches so that
// the decoder's internal queue fills up and it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cbor_hd_pkg::*;

   localparam int StreamBytes = 1826;
   localparam int HoldCycles  = 80;

   typedef struct packed {
      major_type major;
      value_type value;
      logic      indef;
      logic      brk;
      logic      rsv;
      len_type   length;
   } decoded_head_type;

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_stall;
   logic [7:0]        req_data_byte     = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall         = 1'b0;
   logic [2:0]        rsp_major_type;
   logic signed [63:0] rsp_head_value;
   logic              rsp_is_indefinite;
   logic              rsp_is_break;
   logic              rsp_reserved_info;
   logic [3:0]        rsp_head_length;

   byte_type         stream_bytes[$];
   decoded_head_type expected_heads[$];
   int               mismatches   = 0;
   int               bytes_in     = 0;
   int               next_hold_at = 300;
   int               hold_left    = 0;
   logic             steady;

   // decoder state as seen by the predictor
   len_type   args_pending = '0;
   major_type held_major   = '0;
   value_type arg_shift    = '0;
   len_type   bytes_seen   = '0;

   cbor_head_decoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_major_type    (rsp_major_type),
      .rsp_head_value    (rsp_head_value),
      .rsp_is_indefinite (rsp_is_indefinite),
      .rsp_is_break      (rsp_is_break),
      .rsp_reserved_info (rsp_reserved_info),
      .rsp_head_length   (rsp_head_length)
   );

   always #1 clock = ~clock;

   // no random idling on either side in this window
   assign steady = (bytes_in >= 700) && (bytes_in < 1100);

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 50) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
   endtask

   // Advance the predicted decoder by one stream byte.
   task automatic decode_stream_byte(input byte_type b);
      decoded_head_type h;
      logic [4:0]       info;
      logic             done;
      h    = '0;
      info = b[4:0];
      done = 1'b1;
      if (args_pending != 0) begin
         arg_shift    = {arg_shift[55:0], b};
         bytes_seen   = bytes_seen + 4'd1;
         args_pending = args_pending - 4'd1;
         done         = (args_pending == 0);
         h.major      = held_major;
         h.value      = arg_shift;
         h.length     = bytes_seen;
         if (done) begin
            arg_shift  = '0;
            bytes_seen = '0;
         end
      end else begin
         h.major  = b[7:5];
         h.length = 4'd1;
         if (info <= AI_DIRECT_MAX) begin
            h.value = {59'd0, info};
         end else if (info == AI_INDEFINITE) begin
            h.value = '1;
            h.indef = 1'b1;
            h.brk   = (h.major == MAJOR_SIMPLE);
         end else begin
            case (info)
               AI_ONE_BYTE:    args_pending = 4'd1;
               AI_TWO_BYTES:   args_pending = 4'd2;
               AI_FOUR_BYTES:  args_pending = 4'd4;
               AI_EIGHT_BYTES: args_pending = 4'd8;
               default:        args_pending = 4'd0;
            endcase
            if (args_pending == 0) begin
               h.rsv = 1'b1;
            end else begin
               held_major = h.major;
               arg_shift  = '0;
               bytes_seen = 4'd1;
               done       = 1'b0;
            end
         end
      end
      if (done) begin
         // negative integers: -1 - argument, definite arguments only
         if (h.major == MAJOR_NEGATIVE && !h.indef && !h.rsv) begin
            h.value = ~h.value;
         end
         expected_heads.push_back(h);
      end
   endtask

   task automatic check_head(input decoded_head_type got);
      decoded_head_type want;
      if (expected_heads.size() == 0) begin
         report_mismatch($sformatf("head with none expected: major %0d value %h len %0d",
                                   got.major, got.value, got.length));
         return;
      end
      want = expected_heads.pop_front();
      if (got.major !== want.major)
         report_mismatch($sformatf("major_type %0d, want %0d", got.major, want.major));
      if (got.value !== want.value)
         report_mismatch($sformatf("head_value %h, want %h", got.value, want.value));
      if (got.indef !== want.indef)
         report_mismatch($sformatf("is_indefinite %b, want %b", got.indef, want.indef));
      if (got.brk !== want.brk)
         report_mismatch($sformatf("is_break %b, want %b", got.brk, want.brk));
      if (got.rsv !== want.rsv)
         report_mismatch($sformatf("reserved_info %b, want %b", got.rsv, want.rsv));
      if (got.length !== want.length)
         report_mismatch($sformatf("head_length %0d, want %0d", got.length, want.length));
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'h00;
      end else if (!req_valid || !req_stall) begin
         if (stream_bytes.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
            req_valid     <= 1'b1;
            req_data_byte <= stream_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // accepted input items drive the prediction
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         decode_stream_byte(req_data_byte);
         bytes_in <= bytes_in + 1;
      end
   end

   // receiver stall, with long hold-offs at set points in the stream
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (bytes_in >= next_hold_at) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HoldCycles;
         next_hold_at <= next_hold_at + 1000;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 20);
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      decoded_head_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.major  = rsp_major_type;
         seen.value  = rsp_head_value;
         seen.indef  = rsp_is_indefinite;
         seen.brk    = rsp_is_break;
         seen.rsv    = rsp_reserved_info;
         seen.length = rsp_head_length;
         check_head(seen);
      end
   end

   initial begin
      int         pick;
      int         n_args;
      int         fill;
      logic [2:0] major;
      logic [4:0] info;
      // directed heads: immediate extremes, negatives, every argument size,
      // reserved info (also for major 1), indefinite negative, break, and an
      // all-ones 8-byte float that is not a break
      stream_bytes = '{8'h00, 8'h17, 8'h37,
                       8'h18, 8'hff,
                       8'h39, 8'h12, 8'h34,
                       8'h1a, 8'h80, 8'h00, 8'h00, 8'h01,
                       8'hfb, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                       8'h1c, 8'h3e, 8'h3f, 8'hff};
      while (stream_bytes.size() < StreamBytes) begin
         if ($urandom_range(99) < 10) begin
            stream_bytes.push_back(byte_type'($urandom_range(255)));
         end else begin
            major = 3'($urandom_range(7));
            pick  = $urandom_range(9);
            case (pick)
               3:       info = AI_ONE_BYTE;
               4:       info = AI_TWO_BYTES;
               5:       info = AI_FOUR_BYTES;
               6:       info = AI_EIGHT_BYTES;
               7:       info = AI_EIGHT_BYTES;
               8:       info = 5'(28 + $urandom_range(2));
               9:       info = AI_INDEFINITE;
               default: info = 5'($urandom_range(23));
            endcase
            case (info)
               AI_ONE_BYTE:    n_args = 1;
               AI_TWO_BYTES:   n_args = 2;
               AI_FOUR_BYTES:  n_args = 4;
               AI_EIGHT_BYTES: n_args = 8;
               default:        n_args = 0;
            endcase
            fill = $urandom_range(9);
            stream_bytes.push_back({major, info});
            for (int i = 0; i < n_args; i++) begin
               if (fill == 0)
                  stream_bytes.push_back(8'h00);
               else if (fill == 1)
                  stream_bytes.push_back(8'hff);
               else
                  stream_bytes.push_back(byte_type'($urandom_range(255)));
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (stream_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_heads.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0) begin
         $display("** cbor_head_decoder_core: PASSED **");
      end else begin
         $display("** cbor_head_decoder_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("** cbor_head_decoder_core: FAILED **");
      $finish;
   end

endmodule
